// ===== design/fmu_pkg.sv =====
// Shared types, constants and helpers of the binary32 multiplier unit.
package fmu_pkg;

    localparam logic        OP_WRITE  = 1'b0;
    localparam logic        OP_READ   = 1'b1;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          OUT_DEPTH   = 4;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic              is_read;
        logic              is_special;
        logic [31:0]       special_bits;
        logic              sign;
        logic [23:0]       mant_a;
        logic [23:0]       mant_b;
        logic signed [9:0] exp_sum;
    } t_job;

    // Shift that brings the leading one of a nonzero mantissa to bit 23.
    function automatic logic [4:0] lead_shift(input logic [23:0] m);
        logic [4:0] k;
        k = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
                k = 5'(23 - i);
            end
        end
        return k;
    endfunction

endpackage

// ===== design/float32_multiplier_unit.sv =====
// Top level of the IEEE 754 binary32 multiplier unit.
//
// Usage:
//   Input channel (push/full): each request carries i_op, i_operand_a and
//   i_operand_b. It is taken at a clock edge with i_push high and o_full low.
//   i_op = 0 multiplies the operands (round to nearest even, subnormals,
//   infinities, zeros handled; any NaN result is 0x7FC00000) and stores the
//   product; i_op = 1 returns the stored product and ignores the operands.
//   Result channel (empty/pop): o_product holds the oldest result while
//   o_empty is low; it is taken at an edge with i_pop high.
//   Exactly one result per request, in request order.
// Timing:
//   A request passes the decoupling queue, then the 24x24 multiplier
//   register; normalize and round run into the four-entry result queue,
//   which drives the result ports.
//   Throughput is one request per cycle while the result queue has room, set by the single multiplier.
// Reset: clears both queues and sets the stored product to zero.
// Stall: when i_pop stays low the result queue fills, the back end holds,
//   then the decoupling queue fills and o_full rises; nothing is dropped.
module float32_multiplier_unit import fmu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_product
);
    t_job front_job, back_job;
    logic q_wr, q_empty, q_pop;

    // accept a request only while the queue has room
    assign q_wr = i_push && !o_full;

    fmu_front u_front (
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_job       (front_job)
    );

    fmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (front_job),
        .o_full  (o_full),
        .i_rd    (q_pop),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    fmu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (back_job),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_product (o_product)
    );
endmodule

// ===== design/fmu_front.sv =====
// Front end: decode operands, resolve special cases, normalize subnormals.
module fmu_front import fmu_pkg::*; (
    input  logic        i_op,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output t_job        o_job
);
    logic       sign;
    logic [7:0] ea, eb;
    logic [22:0] ma, mb;
    logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [4:0] ka, kb;
    logic signed [9:0] xa, xb;

    always_comb begin
        sign   = i_operand_a[31] ^ i_operand_b[31];
        ea     = i_operand_a[30:23];
        eb     = i_operand_b[30:23];
        ma     = i_operand_a[22:0];
        mb     = i_operand_b[22:0];
        nan_a  = (ea == 8'hFF) && (ma != '0);
        nan_b  = (eb == 8'hFF) && (mb != '0);
        inf_a  = (ea == 8'hFF) && (ma == '0);
        inf_b  = (eb == 8'hFF) && (mb == '0);
        zero_a = (ea == 8'd0) && (ma == '0);
        zero_b = (eb == 8'd0) && (mb == '0);
        ka     = lead_shift({1'b0, ma});
        kb     = lead_shift({1'b0, mb});

        o_job.is_read      = (i_op == OP_READ);
        o_job.sign         = sign;
        o_job.is_special   = 1'b1;
        o_job.special_bits = {sign, 31'd0};
        if (nan_a || nan_b || ((inf_a || inf_b) && (zero_a || zero_b))) begin
            o_job.special_bits = QNAN_BITS;
        end else if (inf_a || inf_b) begin
            o_job.special_bits = {sign, INF_MAG};
        end else if (!(zero_a || zero_b)) begin
            o_job.is_special = 1'b0;
        end

        // subnormals: shift the leading one up and lower the exponent to match
        if (ea == 8'd0) begin
            o_job.mant_a = {1'b0, ma} << ka;
            xa           = 10'sd1 - signed'({5'd0, ka});
        end else begin
            o_job.mant_a = {1'b1, ma};
            xa           = signed'({2'd0, ea});
        end
        if (eb == 8'd0) begin
            o_job.mant_b = {1'b0, mb} << kb;
            xb           = 10'sd1 - signed'({5'd0, kb});
        end else begin
            o_job.mant_b = {1'b1, mb};
            xb           = signed'({2'd0, eb});
        end
        o_job.exp_sum = xa + xb - 10'sd127;
    end
endmodule

// ===== design/fmu_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module fmu_queue import fmu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
        if (i_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ===== design/fmu_back.sv =====
// Back end: mantissa multiply, normalize and round, product store, result queue.
module fmu_back import fmu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_product
);
    logic              r_s1_v;
    t_job              r_s1_job;
    logic [47:0]       r_s1_p;
    logic [31:0]       r_last;
    logic [31:0]       r_out [OUT_DEPTH];
    logic [1:0]        r_wp, r_rp;
    logic [2:0]        r_cnt;

    logic              rd;
    logic signed [9:0] e, e_inc;
    logic [47:0]       mant, mask;
    logic [5:0]        d;
    logic [71:0]       shifted;
    logic [23:0]       q;
    logic              guard, sticky, inc;
    logic [24:0]       qr;
    logic [31:0]       res, n_last;

    assign o_q_pop   = !i_q_empty && ((r_cnt + 3'(r_s1_v)) < 3'(OUT_DEPTH));
    assign rd        = i_pop && (r_cnt != 3'd0);
    assign o_empty   = (r_cnt == 3'd0);
    assign o_product = r_out[r_rp];

    always_comb begin
        e    = r_s1_job.exp_sum + signed'({9'd0, r_s1_p[47]});
        mant = r_s1_p[47] ? r_s1_p : {r_s1_p[46:0], 1'b0};
        if (e > 10'sd0) begin
            d = 6'd0;
        end else if (e < -10'sd48) begin
            d = 6'd49;
        end else begin
            d = 6'(10'sd1 - e);
        end
        shifted = {mant, 24'd0} >> d;
        mask    = ~(48'hFFFF_FFFF_FFFF << d);
        q       = shifted[71:48];
        guard   = shifted[47];
        sticky  = (shifted[46:24] != '0) || ((mant & mask) != '0);
        inc     = guard && (sticky || q[0]);
        qr      = {1'b0, q} + 25'(inc);
        e_inc   = e + 10'sd1;

        if (r_s1_job.is_special) begin
            res = r_s1_job.special_bits;
        end else if (e >= 10'sd255) begin
            res = {r_s1_job.sign, INF_MAG};
        end else if (e <= 10'sd0) begin
            res = {r_s1_job.sign, 7'd0, qr[23:0]};
        end else if (qr[24]) begin
            res = (e_inc >= 10'sd255) ? {r_s1_job.sign, INF_MAG}
                                      : {r_s1_job.sign, e_inc[7:0], 23'd0};
        end else begin
            res = {r_s1_job.sign, e[7:0], qr[22:0]};
        end
        n_last = r_s1_job.is_read ? r_last : res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_last <= 32'd0;
            r_wp   <= 2'd0;
            r_rp   <= 2'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_s1_v <= o_q_pop;
            if (r_s1_v) begin
                r_last <= n_last;
                r_wp   <= r_wp + 2'd1;
            end
            if (rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(r_s1_v) - 3'(rd);
        end
        if (o_q_pop) begin
            r_s1_job <= i_job;
            r_s1_p   <= i_job.mant_a * i_job.mant_b;
        end
        if (r_s1_v) begin
            r_out[r_wp] <= n_last;
        end
    end
endmodule
